// File: rtl/mcss_pkg.sv
// mcss_pkg: shared types, constants and the Q.16 product helper for the
// matcap sphere shader. No dependencies; used by the top level, mcss_shade and the tb files.
package mcss_pkg;

   // Q.16 fixed point, 65536 = 1.0, values here stay within 0..1 (17 bits)
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   // configuration register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_BASE_RED   = 2'd0;
   localparam csr_index_type CSR_BASE_GREEN = 2'd1;
   localparam csr_index_type CSR_BASE_BLUE  = 2'd2;

   localparam logic [15:0] BASE_RED_RST   = 16'd20316;
   localparam logic [15:0] BASE_GREEN_RST = 16'd19005;
   localparam logic [15:0] BASE_BLUE_RST  = 16'd18350;

   // light directions, Q.16 signed: key, half vector, fill
   typedef logic signed [17:0] dir_type;
   localparam int DOT_KEY  = 0;
   localparam int DOT_HALF = 1;
   localparam int DOT_FILL = 2;
   localparam dir_type DIR_X [3] = '{18'sd23008, 18'sd12582, -18'sd33564};
   localparam dir_type DIR_Y [3] = '{18'sd42729, 18'sd23366, -18'sd25173};
   localparam dir_type DIR_Z [3] = '{18'sd44044, 18'sd59922, 18'sd50346};

   // mixing weights, Q.16
   localparam logic [16:0] AMBIENT    = 17'd7864;
   localparam logic [16:0] KEY_GAIN   = 17'd42598;
   localparam logic [16:0] FILL_W_RG  = 17'd7864;
   localparam logic [16:0] FILL_W_B   = 17'd6554;
   localparam logic [16:0] SPEC_GAIN  = 17'd29491;
   localparam logic [16:0] RIM_GAIN   = 17'd22938;
   localparam logic [16:0] RIM_K_R    = 17'd19661;
   localparam logic [16:0] RIM_K_G    = 17'd16384;
   localparam logic [16:0] RIM_K_B    = 17'd18350;
   localparam int          FADE_GAIN  = 2621;

   // sphere point handed from the front end to the shading pipe
   typedef struct packed {
      logic signed [17:0] u;
      logic signed [17:0] v;
      logic [16:0]        z;
      logic [16:0]        radius;
      logic               outside;
   } geom_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } base_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // truncating product of two Q.16 values in 0..1
   function automatic logic [16:0] qmul(input logic [16:0] a, input logic [16:0] b);
      logic [33:0] p;
      p = 34'(a) * 34'(b);
      return p[32:16];
   endfunction

endpackage

// File: rtl/matcap_sphere_shader_unit.sv
// matcap_sphere_shader_unit: top level of the matcap sphere shader.
// Depends on mcss_pkg, mcss_isqrt and mcss_shade.
//
//   channel | direction | ports                      | beat carries
//   --------+-----------+----------------------------+-----------------------------
//   req     | in        | req_tvalid/tready/tdata    | one pixel coordinate
//   rsp     | out       | rsp_tvalid/tready/tdata    | one RGBA texel
//   csr     | in        | csr_valid/ready/index/data | one base color register write
//
// One pixel enters per cycle while the pipe is not stalled; a texel leaves through
// 4 coordinate stages, 17 square root stages, 12 shading stages and the output register.
// The square root pipe is the deepest part and sets the latency.
// Reset clears the valid bits and loads the base colors; csr_ready is always high.
// A stall holds every stage while the last stage and the output register are both
// full and the output is not taken; with the last stage empty the pipe keeps moving.
module matcap_sphere_shader_unit #(
   parameter int SIZE = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [8:0] pixel_x, [17:9] pixel_y, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] red_byte, [15:8] green_byte,
                                    // [23:16] blue_byte, [31:24] alpha_byte
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int LAT = 33;

   // coordinate mapping: round(p * 2^17 / (SIZE-1)) by reciprocal multiply
   localparam logic [63:0] MAP_DEN    = 64'(SIZE - 1);
   localparam logic [63:0] MAP_HALF   = MAP_DEN / 64'd2;
   localparam logic [63:0] MAP_MUL    = ((64'd1 << 39) + MAP_DEN - 64'd1) / MAP_DEN;
   localparam logic [19:0] MAP_MUL_HI = MAP_MUL[35:16];
   localparam logic [15:0] MAP_MUL_LO = MAP_MUL[15:0];

   typedef struct packed {
      logic signed [17:0] u;
      logic [16:0]        mag;
      logic               big;
   } coord_type;

   typedef struct packed {
      logic signed [17:0] u;
      logic signed [17:0] v;
      logic               outside;
   } side_type;

   function automatic coord_type decode(input logic [46:0] hi, input logic [42:0] lo);
      logic [63:0]        full;
      logic signed [25:0] w;
      logic [25:0]        mag;
      coord_type          c;
      full  = {1'b0, hi, 16'd0} + 64'(lo);
      w     = $signed({1'b0, full[63:39]}) - 26'sd65536;
      mag   = (w < 0) ? 26'(-w) : 26'(w);
      c.big = mag > 26'd65536;
      c.u   = c.big ? 18'sd0 : w[17:0];
      c.mag = c.big ? 17'd0 : mag[16:0];
      return c;
   endfunction

   // pipeline control
   logic       valid_ff [LAT];
   logic       en;
   logic       rsp_tvalid_ff;
   logic [31:0] rsp_tdata_ff;

   assign en         = !valid_ff[LAT-1] || !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= req_tvalid;
         for (int k = 1; k < LAT; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // base color registers
   mcss_pkg::base_type base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff.red   <= mcss_pkg::BASE_RED_RST;
         base_ff.green <= mcss_pkg::BASE_GREEN_RST;
         base_ff.blue  <= mcss_pkg::BASE_BLUE_RST;
      end else if (csr_valid) begin
         case (mcss_pkg::csr_index_type'(csr_index))
            mcss_pkg::CSR_BASE_RED:   base_ff.red   <= csr_data;
            mcss_pkg::CSR_BASE_GREEN: base_ff.green <= csr_data;
            mcss_pkg::CSR_BASE_BLUE:  base_ff.blue  <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 1: reciprocal partial products
   logic [26:0] num_x;
   logic [26:0] num_y;
   logic [46:0] hi_x_ff;
   logic [42:0] lo_x_ff;
   logic [46:0] hi_y_ff;
   logic [42:0] lo_y_ff;

   assign num_x = {1'b0, req_tdata[8:0], 17'd0} + MAP_HALF[26:0];
   assign num_y = {1'b0, req_tdata[17:9], 17'd0} + MAP_HALF[26:0];

   always_ff @(posedge clock) begin
      if (en) begin
         hi_x_ff <= 47'(num_x) * 47'(MAP_MUL_HI);
         lo_x_ff <= 43'(num_x) * 43'(MAP_MUL_LO);
         hi_y_ff <= 47'(num_y) * 47'(MAP_MUL_HI);
         lo_y_ff <= 43'(num_y) * 43'(MAP_MUL_LO);
      end
   end

   // stage 2: centered coordinates and magnitudes
   coord_type cx_ff;
   coord_type cy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff <= decode(hi_x_ff, lo_x_ff);
         cy_ff <= decode(hi_y_ff, lo_y_ff);
      end
   end

   // stage 3: squares
   logic [33:0] sq_x_ff;
   logic [33:0] sq_y_ff;
   coord_type   cx3_ff;
   coord_type   cy3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_x_ff <= 34'(cx_ff.mag) * 34'(cx_ff.mag);
         sq_y_ff <= 34'(cy_ff.mag) * 34'(cy_ff.mag);
         cx3_ff  <= cx_ff;
         cy3_ff  <= cy_ff;
      end
   end

   // stage 4: disc test and square root operands
   logic [34:0] r2full;
   logic        outside_in;
   logic [16:0] r2;
   logic [32:0] rad_z_ff;
   logic [32:0] rad_r_ff;
   side_type    side4_ff;

   always_comb begin
      r2full     = 35'(sq_x_ff) + 35'(sq_y_ff);
      outside_in = cx3_ff.big || cy3_ff.big || (r2full > 35'h1_0000_0000);
      r2         = r2full[32:16];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_z_ff         <= outside_in ? 33'd0 : {mcss_pkg::ONE_Q16 - r2, 16'd0};
         rad_r_ff         <= outside_in ? 33'd0 : {r2, 16'd0};
         side4_ff.u       <= cx3_ff.u;
         side4_ff.v       <= cy3_ff.u;
         side4_ff.outside <= outside_in;
      end
   end

   // square roots for depth and radius, sideband delayed alongside
   logic [16:0] z_root;
   logic [16:0] radius_root;
   side_type    side_ff [17];

   mcss_isqrt u_isqrt_z (
      .clock    (clock),
      .en       (en),
      .radicand (rad_z_ff),
      .root     (z_root)
   );

   mcss_isqrt u_isqrt_radius (
      .clock    (clock),
      .en       (en),
      .radicand (rad_r_ff),
      .root     (radius_root)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side4_ff;
         for (int k = 1; k < 17; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // shading pipe
   mcss_pkg::geom_type  geom;
   mcss_pkg::pixel_type pixel;

   assign geom.u       = side_ff[16].u;
   assign geom.v       = side_ff[16].v;
   assign geom.z       = z_root;
   assign geom.radius  = radius_root;
   assign geom.outside = side_ff[16].outside;

   mcss_shade #(
      .SIZE (SIZE)
   ) u_shade (
      .clock (clock),
      .en    (en),
      .geom  (geom),
      .base  (base_ff),
      .pixel (pixel)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (!rsp_tvalid_ff || rsp_tready) begin
         rsp_tvalid_ff <= valid_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_tvalid_ff || rsp_tready) begin
         rsp_tdata_ff <= pixel;
      end
   end

   // transparent texels carry no color
   a_clear_outside : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && (rsp_tdata_ff[31:24] == 8'd0) |-> (rsp_tdata_ff[23:0] == 24'd0))
      else $error("color bytes set on a transparent texel");

   // alpha is either fully off or fully on
   a_alpha_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_tdata_ff[31:24] == 8'd0) || (rsp_tdata_ff[31:24] == 8'd255))
      else $error("alpha byte neither 0 nor 255");

   // an accepted beat enters the first stage
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted beat missing from first stage");

   // a blocked finished texel stays in the last stage
   a_hold_last : assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAT-1] && rsp_tvalid_ff && !rsp_tready |=> valid_ff[LAT-1])
      else $error("last stage dropped a texel during a stall");

endmodule

// File: rtl/mcss_isqrt.sv
// mcss_isqrt: pipelined integer square root, one result bit per stage.
// Depends on nothing; floor(sqrt(radicand)) comes out of the last stage, stages move only while en is high.
module mcss_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [32:0] radicand,
   output logic [16:0] root
);

   localparam int STEPS = 17;
   localparam int W     = 35;

   logic [W-1:0] rem_ff [STEPS];
   logic [W-1:0] acc_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic [W-1:0] BIT = W'(1) << (2 * (STEPS - 1 - i));
      logic [W-1:0] rem_d;
      logic [W-1:0] acc_d;
      logic [W-1:0] trial;
      logic [W-1:0] rem_in;
      logic [W-1:0] acc_in;

      if (i == 0) begin : g_first
         assign rem_d = W'(radicand);
         assign acc_d = '0;
      end else begin : g_next
         assign rem_d = rem_ff[i-1];
         assign acc_d = acc_ff[i-1];
      end

      // one restoring step: subtract trial when it fits
      always_comb begin
         trial = acc_d + BIT;
         if (rem_d >= trial) begin
            rem_in = rem_d - trial;
            acc_in = (acc_d >> 1) + BIT;
         end else begin
            rem_in = rem_d;
            acc_in = acc_d >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            acc_ff[i] <= acc_in;
         end
      end
   end

   assign root = acc_ff[STEPS-1][16:0];

endmodule

// File: rtl/mcss_shade.sv
// mcss_shade: twelve-stage lighting pipe from sphere point to RGBA bytes.
// Depends on mcss_pkg; the final byte scaling is combinational off stage 12.
module mcss_shade #(
   parameter int SIZE = 512
) (
   input  logic               clock,
   input  logic               en,
   input  mcss_pkg::geom_type geom,
   input  mcss_pkg::base_type base,
   output mcss_pkg::pixel_type pixel
);

   localparam logic [23:0] FADE_K = 24'(SIZE * mcss_pkg::FADE_GAIN);

   typedef struct packed {
      logic [17:0] lit_red;
      logic [17:0] lit_green;
      logic [17:0] lit_blue;
      logic [16:0] rim_red;
      logic [16:0] rim_green;
      logic [16:0] rim_blue;
      logic [16:0] fade;
      logic        outside;
   } carry_type;

   // stage 1: dot product terms, rim base, fade product
   logic signed [35:0] pu_in [3];
   logic signed [35:0] pv_in [3];
   logic signed [35:0] pz_in [3];
   logic signed [35:0] pu_ff [3];
   logic signed [35:0] pv_ff [3];
   logic signed [35:0] pz_ff [3];
   logic [16:0] rim_t1_in;
   logic [16:0] rim_t1_ff;
   logic [40:0] fade_prod_in;
   logic [40:0] fade_prod_ff;
   logic        out1_ff;

   always_comb begin
      for (int d = 0; d < 3; d++) begin
         pu_in[d] = geom.u * mcss_pkg::DIR_X[d];
         pv_in[d] = geom.v * mcss_pkg::DIR_Y[d];
         pz_in[d] = $signed({1'b0, geom.z}) * mcss_pkg::DIR_Z[d];
      end
      rim_t1_in    = mcss_pkg::ONE_Q16 - geom.z;
      fade_prod_in = 41'(mcss_pkg::ONE_Q16 - geom.radius) * 41'(FADE_K);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pu_ff        <= pu_in;
         pv_ff        <= pv_in;
         pz_ff        <= pz_in;
         rim_t1_ff    <= rim_t1_in;
         fade_prod_ff <= fade_prod_in;
         out1_ff      <= geom.outside;
      end
   end

   // stage 2: dot sums with clamp, rim square, fade limit
   logic [16:0] dot_in [3];
   logic [16:0] dot_ff [3];
   logic [16:0] rim_tt2_in;
   logic [16:0] rim_tt2_ff;
   logic [16:0] rim_t2_ff;
   logic [16:0] fade2_in;
   logic [16:0] fade2_ff;
   logic        out2_ff;

   always_comb begin
      logic signed [37:0] s;
      for (int d = 0; d < 3; d++) begin
         s = 38'(pu_ff[d]) - 38'(pv_ff[d]) + 38'(pz_ff[d]);
         if (s <= 38'sd0) begin
            dot_in[d] = '0;
         end else if (s[37:16] > 22'd65536) begin
            dot_in[d] = mcss_pkg::ONE_Q16;
         end else begin
            dot_in[d] = s[32:16];
         end
      end
      rim_tt2_in = mcss_pkg::qmul(rim_t1_ff, rim_t1_ff);
      if (fade_prod_ff[40:16] > 25'd65536) begin
         fade2_in = mcss_pkg::ONE_Q16;
      end else begin
         fade2_in = fade_prod_ff[32:16];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dot_ff     <= dot_in;
         rim_tt2_ff <= rim_tt2_in;
         rim_t2_ff  <= rim_t1_ff;
         fade2_ff   <= fade2_in;
         out2_ff    <= out1_ff;
      end
   end

   // stage 3: first specular square, rim cube, diffuse products
   logic [16:0] n2_ff;
   logic [16:0] ndoth3_ff;
   logic [16:0] rim_ttt3_ff;
   logic [16:0] key3_ff;
   logic [16:0] fill_rg3_ff;
   logic [16:0] fill_b3_ff;
   logic [16:0] fade3_ff;
   logic        out3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         n2_ff       <= mcss_pkg::qmul(dot_ff[mcss_pkg::DOT_HALF], dot_ff[mcss_pkg::DOT_HALF]);
         ndoth3_ff   <= dot_ff[mcss_pkg::DOT_HALF];
         rim_ttt3_ff <= mcss_pkg::qmul(rim_tt2_ff, rim_t2_ff);
         key3_ff     <= mcss_pkg::qmul(dot_ff[mcss_pkg::DOT_KEY], mcss_pkg::KEY_GAIN);
         fill_rg3_ff <= mcss_pkg::qmul(dot_ff[mcss_pkg::DOT_FILL], mcss_pkg::FILL_W_RG);
         fill_b3_ff  <= mcss_pkg::qmul(dot_ff[mcss_pkg::DOT_FILL], mcss_pkg::FILL_W_B);
         fade3_ff    <= fade2_ff;
         out3_ff     <= out2_ff;
      end
   end

   // stage 4: fourth power, rim weight, light sums
   logic [16:0] n4_ff;
   logic [16:0] ndoth4_ff;
   logic [16:0] rim4_ff;
   logic [16:0] light_rg4_ff;
   logic [16:0] light_b4_ff;
   logic [16:0] fade4_ff;
   logic        out4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         n4_ff        <= mcss_pkg::qmul(n2_ff, n2_ff);
         ndoth4_ff    <= ndoth3_ff;
         rim4_ff      <= mcss_pkg::qmul(rim_ttt3_ff, mcss_pkg::RIM_GAIN);
         light_rg4_ff <= mcss_pkg::AMBIENT + key3_ff + fill_rg3_ff;
         light_b4_ff  <= mcss_pkg::AMBIENT + key3_ff + fill_b3_ff;
         fade4_ff     <= fade3_ff;
         out4_ff      <= out3_ff;
      end
   end

   // stage 5: fifth power, base color products, per channel rim
   logic [16:0] n5_ff;
   carry_type   carry_in;
   carry_type   carry_ff [6];
   logic [32:0] lit_r;
   logic [32:0] lit_g;
   logic [32:0] lit_b;

   always_comb begin
      lit_r = 33'(base.red) * 33'(light_rg4_ff);
      lit_g = 33'(base.green) * 33'(light_rg4_ff);
      lit_b = 33'(base.blue) * 33'(light_b4_ff);
      carry_in.lit_red   = lit_r[32:15];
      carry_in.lit_green = lit_g[32:15];
      carry_in.lit_blue  = lit_b[32:15];
      carry_in.rim_red   = mcss_pkg::qmul(rim4_ff, mcss_pkg::RIM_K_R);
      carry_in.rim_green = mcss_pkg::qmul(rim4_ff, mcss_pkg::RIM_K_G);
      carry_in.rim_blue  = mcss_pkg::qmul(rim4_ff, mcss_pkg::RIM_K_B);
      carry_in.fade      = fade4_ff;
      carry_in.outside   = out4_ff;
   end

   // stages 6 to 9: repeated squaring to the 80th power
   logic [16:0] pow_ff [4];

   always_ff @(posedge clock) begin
      if (en) begin
         n5_ff       <= mcss_pkg::qmul(n4_ff, ndoth4_ff);
         carry_ff[0] <= carry_in;
         for (int k = 1; k < 6; k++) begin
            carry_ff[k] <= carry_ff[k-1];
         end
         pow_ff[0] <= mcss_pkg::qmul(n5_ff, n5_ff);
         for (int k = 1; k < 4; k++) begin
            pow_ff[k] <= mcss_pkg::qmul(pow_ff[k-1], pow_ff[k-1]);
         end
      end
   end

   // stage 10: specular weight
   logic [16:0] spec_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         spec_ff <= mcss_pkg::qmul(pow_ff[3], mcss_pkg::SPEC_GAIN);
      end
   end

   // stage 11: channel sums limited to one
   logic [16:0] chan_in [3];
   logic [16:0] chan_ff [3];
   logic [16:0] fade11_ff;
   logic        out11_ff;

   always_comb begin
      logic [18:0] sum [3];
      sum[0] = 19'(carry_ff[5].lit_red) + 19'(spec_ff) + 19'(carry_ff[5].rim_red);
      sum[1] = 19'(carry_ff[5].lit_green) + 19'(spec_ff) + 19'(carry_ff[5].rim_green);
      sum[2] = 19'(carry_ff[5].lit_blue) + 19'(spec_ff) + 19'(carry_ff[5].rim_blue);
      for (int c = 0; c < 3; c++) begin
         chan_in[c] = (sum[c] > 19'd65536) ? mcss_pkg::ONE_Q16 : sum[c][16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         chan_ff   <= chan_in;
         fade11_ff <= carry_ff[5].fade;
         out11_ff  <= carry_ff[5].outside;
      end
   end

   // stage 12: edge fade
   logic [33:0] faded_ff [3];
   logic        out12_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            faded_ff[c] <= 34'(chan_ff[c]) * 34'(fade11_ff);
         end
         out12_ff <= out11_ff;
      end
   end

   // byte scaling: (x * 255) >> 32
   logic [41:0] scaled [3];
   logic [7:0]  chan_byte [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         scaled[c]    = {faded_ff[c], 8'd0} - 42'(faded_ff[c]);
         chan_byte[c] = out12_ff ? 8'd0 : scaled[c][39:32];
      end
      pixel.red   = chan_byte[0];
      pixel.green = chan_byte[1];
      pixel.blue  = chan_byte[2];
      pixel.alpha = out12_ff ? 8'd0 : 8'd255;
   end

endmodule

// File: tb/mcss_checker.sv
// mcss_checker: watches the pixel, texel and register channels of the matcap
// sphere shader, predicts each texel and compares. Depends on mcss_pkg.
module mcss_checker #(
   parameter int SIZE = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          texel_count,
   output int          pending_texels
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint UNIT = 65536;

   logic [15:0] red_reg, green_reg, blue_reg;
   mcss_pkg::pixel_type texel_queue [$];

   assign pending_texels = texel_queue.size();

   function automatic longint int_sqrt(longint a);
      longint r, b;
      r = 0;
      b = 64'sd1 << 60;
      while (b > a) b = b >>> 2;
      while (b != 0) begin
         if (a >= r + b) begin
            a = a - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint to_unit(longint p);
      longint den;
      den = SIZE - 1;
      return (p * 2 * UNIT + den / 2) / den - UNIT;
   endfunction

   function automatic longint dot_clamp(longint u, longint v, longint z,
                                        longint cx, longint cy, longint cz);
      longint s;
      s = u * cx - v * cy + z * cz;
      if (s <= 0) return 0;
      s = s >>> 16;
      return (s > UNIT) ? UNIT : s;
   endfunction

   function automatic longint fx(longint a, longint b);
      return (a * b) >>> 16;
   endfunction

   function automatic logic [7:0] mix_channel(longint base, longint fw, longint rk,
                                              longint key, longint fil, longint sp,
                                              longint rim, longint fade);
      longint lit, c;
      lit = 7864 + fx(key, 42598) + fx(fil, fw);
      c = ((base * lit) >>> 15) + fx(sp, 29491) + fx(rim, rk);
      if (c > UNIT) c = UNIT;
      return 8'((c * fade * 255) >>> 32);
   endfunction

   function automatic mcss_pkg::pixel_type shade_texel(logic [8:0] px, logic [8:0] py);
      mcss_pkg::pixel_type t;
      longint u, v, r2, z, rad, key, half, fil, n, n5, tt, rim, fade;
      u = to_unit(longint'(px));
      v = to_unit(longint'(py));
      t = '0;
      if (u * u + v * v > (UNIT << 16)) return t;
      r2 = (u * u + v * v) >>> 16;
      z = int_sqrt((UNIT - r2) << 16);
      rad = int_sqrt(r2 << 16);
      key = dot_clamp(u, v, z, 23008, 42729, 44044);
      half = dot_clamp(u, v, z, 12582, 23366, 59922);
      fil = dot_clamp(u, v, z, -33564, -25173, 50346);
      n = fx(half, half);
      n = fx(n, n);
      n5 = fx(n, half);
      n = fx(n5, n5);
      n = fx(n, n);
      n = fx(n, n);
      n = fx(n, n);
      tt = UNIT - ((z > UNIT) ? UNIT : z);
      rim = fx(fx(fx(tt, tt), tt), 22938);
      tt = UNIT - ((rad > UNIT) ? UNIT : rad);
      fade = (tt * SIZE * 2621) >>> 16;
      if (fade > UNIT) fade = UNIT;
      t.red = mix_channel(longint'(red_reg), 7864, 19661, key, fil, n, rim, fade);
      t.green = mix_channel(longint'(green_reg), 7864, 16384, key, fil, n, rim, fade);
      t.blue = mix_channel(longint'(blue_reg), 6554, 18350, key, fil, n, rim, fade);
      t.alpha = 8'd255;
      return t;
   endfunction

   // register writes, pixel beats and texel beats
   always @(posedge clock) begin
      mcss_pkg::pixel_type want, got;
      if (reset) begin
         red_reg <= mcss_pkg::BASE_RED_RST;
         green_reg <= mcss_pkg::BASE_GREEN_RST;
         blue_reg <= mcss_pkg::BASE_BLUE_RST;
         texel_queue.delete();
         fail_count <= 0;
         texel_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mcss_pkg::CSR_BASE_RED: red_reg <= csr_data;
               mcss_pkg::CSR_BASE_GREEN: green_reg <= csr_data;
               mcss_pkg::CSR_BASE_BLUE: blue_reg <= csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            texel_queue.push_back(shade_texel(req_tdata[8:0], req_tdata[17:9]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            texel_count <= texel_count + 1;
            if (texel_queue.size() == 0) begin
               $display("%0t: unexpected texel, expected none, got %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = texel_queue.pop_front();
               if (want != got) begin
                  $display("%0t: texel mismatch expected r%0d g%0d b%0d a%0d,",
                           $time, want.red, want.green, want.blue, want.alpha);
                  $display("   got r%0d g%0d b%0d a%0d",
                           got.red, got.green, got.blue, got.alpha);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: tb/tb.sv
// tb: stimulus and verdict for matcap_sphere_shader_unit.
// Depends on mcss_pkg, the rtl and mcss_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIZE = 512;
   localparam int LATENCY = 34;
   localparam int STALL_LIMIT = 4000;
   // an index past the register list
   localparam mcss_pkg::csr_index_type CSR_SPARE = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = mcss_pkg::CSR_BASE_RED;
   logic [15:0] csr_data = '0;
   int          fail_count, texel_count, pending_texels;
   int          send_idle_pct = 0, stall_pct = 0;
   int          idle_cycles = 0;
   int          pixel_count = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   matcap_sphere_shader_unit #(.SIZE(SIZE)) u_top (.*);

   mcss_checker #(.SIZE(SIZE)) u_check (.*);

   // receiver back pressure
   always @(negedge clock)
      rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);

   // watchdog on cycles with no beat accepted
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // valid stays up after the beat so back to back beats need no second update
   task automatic send_pixel(logic [8:0] px, logic [8:0] py);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'b0, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      pixel_count++;
   endtask

   task automatic write_base(mcss_pkg::csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic drain;
      req_tvalid <= 0;
      while (pending_texels != 0) @(negedge clock);
   endtask

   // mostly inside the disc, with the rim, corners and far edges mixed in
   task automatic random_pixels(int count);
      logic [8:0] px, py;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0: begin px = 9'($urandom); py = 9'($urandom); end
            1: begin px = $urandom_range(1) ? 9'd0 : 9'd511; py = 9'($urandom); end
            2: begin px = 9'($urandom); py = $urandom_range(1) ? 9'd0 : 9'd511; end
            default: begin
               px = 9'($urandom_range(440, 70));
               py = 9'($urandom_range(440, 70));
            end
         endcase
         send_pixel(px, py);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: corners, center, rim points, field extremes
      send_pixel(9'd0, 9'd0);
      send_pixel(9'd511, 9'd511);
      send_pixel(9'd0, 9'd511);
      send_pixel(9'd511, 9'd0);
      send_pixel(9'd255, 9'd255);
      send_pixel(9'd256, 9'd256);
      send_pixel(9'd0, 9'd255);
      send_pixel(9'd511, 9'd256);
      send_pixel(9'd255, 9'd0);
      send_pixel(9'd256, 9'd511);
      send_pixel(9'h155, 9'h0AA);
      send_pixel(9'h0AA, 9'h155);
      send_pixel(9'd180, 9'd150);
      send_pixel(9'd330, 9'd360);
      drain();
      repeat (LATENCY + 4) @(negedge clock);

      // base color extremes, including above unity and unlisted index
      write_base(mcss_pkg::CSR_BASE_RED, 16'd0);
      write_base(mcss_pkg::CSR_BASE_GREEN, 16'd32768);
      write_base(mcss_pkg::CSR_BASE_BLUE, 16'hFFFF);
      write_base(CSR_SPARE, 16'h1234);
      send_pixel(9'd180, 9'd150);
      send_pixel(9'd255, 9'd255);
      send_pixel(9'd40, 9'd255);
      send_pixel(9'd400, 9'd300);
      random_pixels(20);
      drain();
      repeat (LATENCY + 4) @(negedge clock);

      // random phases with random base colors
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 85; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 85; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         write_base(mcss_pkg::CSR_BASE_RED, 16'($urandom));
         write_base(mcss_pkg::CSR_BASE_GREEN, 16'($urandom_range(32768)));
         write_base(mcss_pkg::CSR_BASE_BLUE, 16'($urandom_range(32768)));
         random_pixels(125);
         drain();
         repeat (LATENCY + 4) @(negedge clock);
      end

      $display("sent %0d pixels, checked %0d texels over four idle/stall mixes",
               pixel_count, texel_count);
      if (fail_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end
endmodule

// File: sim.f
rtl/mcss_pkg.sv
rtl/mcss_isqrt.sv
rtl/mcss_shade.sv
rtl/matcap_sphere_shader_unit.sv
tb/mcss_checker.sv
tb/tb.sv
